### hw/rtl/fpd_pkg.sv
package fpd_pkg;

	localparam int GUARD_BITS = 16;
	localparam int GAIN_FRAC  = 18;
	localparam int ATAN_COUNT = 24;

	localparam int FREQ_W  = 24;
	localparam int LIMIT_W = 23;
	localparam int COEF_W  = 18;
	localparam int OGAIN_W = 16;
	localparam int DC_W    = 42;
	localparam int DIFF_W  = 43;
	localparam int DLO_W   = 22;
	localparam int ACC_W   = 62;
	localparam int AUDIO_W = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;

	localparam logic [CFG_IDX_W-1:0] REG_LOOP_ALPHA = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_BETA  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DC_ALPHA   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_GAIN   = 3'd4;

	// atan(2^-k) in 2^-32 turn
	localparam logic [31:0] ATAN_TURN32 [ATAN_COUNT] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
	};

	// step angle rounded to the phase resolution
	function automatic logic [31:0] atan_step(input logic [4:0] k, input int pbits);
		logic [33:0] t;
		logic [33:0] r;
		t = {1'b0, ATAN_TURN32[k], 1'b0} >> (32 - pbits);
		r = (t + 34'd1) >> 1;
		return r[31:0];
	endfunction

endpackage

### hw/rtl/fm_pll_demodulator.sv
// fm_pll_demodulator: second-order pll fm demodulator
// input channel: one complex sample (sample_i, sample_q) per request,
// taken on in_valid && in_ready. in_ready is high only while the
// sequencer is idle.
// output channel: one audio_out per input, held in an output register
// until out_valid && out_ready.
// config channel: cfg_index/cfg_data written on cfg_valid && cfg_ready,
// cfg_ready is always high; unknown indexes are dropped.
// sequence: a sample runs through the cordic vectoring iterations
// (one stage per cycle; skipped for an all-zero sample) and then the
// loop update, which runs its six products through one shared
// multiplier with an 18-bit coefficient operand.
// a new sample is taken the cycle after the result is loaded.
// stalls: a result waiting on out_ready does not block a new sample;
// the following result waits at the end of its sequence until the
// output register frees up.
// reset: nco phase, loop frequency and dc estimate clear to zero,
// gains and freq limit clear to zero, out_gain to 256 (2^-8, 16 fraction bits).
module fm_pll_demodulator import fpd_pkg::*; #(
	parameter int PHASE_BITS    = 24,
	parameter int CORDIC_STAGES = 16,
	parameter int SAMPLE_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample_i,
	input  logic signed [SAMPLE_BITS-1:0] sample_q,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [AUDIO_W-1:0]     audio_out,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data
);

	localparam int MW = (PHASE_BITS + 1 > DLO_W + 1) ? PHASE_BITS + 1 : DLO_W + 1;
	localparam int PW = MW + COEF_W + 1;
	localparam int NW = MW + 2;

	typedef enum logic [3:0] {
		S_IDLE, S_ROT, S_ERR, S_MB, S_FRQ, S_PH, S_DL, S_DH, S_DC, S_D2,
		S_OL, S_OH, S_OUT
	} state_t;

	state_t state_q;

	logic [COEF_W-1:0]  loop_alpha_q, loop_beta_q, dc_alpha_q;
	logic [LIMIT_W-1:0] freq_limit_q;
	logic [OGAIN_W-1:0] out_gain_q;

	logic [PHASE_BITS-1:0]    nco_q;
	logic signed [FREQ_W-1:0] lf_q;
	logic signed [DC_W-1:0]   dc_q;
	logic signed [MW-1:0]     err_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [PW-1:0]     prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     zero_q;
	logic                     out_valid_q;
	logic signed [AUDIO_W-1:0] audio_q;

	logic                  accept, cor_start, cor_done, in_zero;
	logic [PHASE_BITS-1:0] cor_angle, s_sum;
	logic signed [MW-1:0]  s_ext, err_n, mul_a;
	logic [COEF_W-1:0]     mul_b;
	logic signed [PW-1:0]  prod, pr_rnd, pr_shift;
	logic signed [NW-1:0]  rnd_p, freq_sum, lim, neg_lim, lf_ext, ph_sum, nco_ext;
	logic signed [DIFF_W-1:0] diff_n;
	logic signed [ACC_W-1:0]  acc_sum, acc_dc, acc_out;
	logic signed [DC_W-1:0]   dc_n;

	assign in_zero   = (sample_i == '0) && (sample_q == '0);
	assign accept    = in_valid && in_ready;
	assign cor_start = accept && !in_zero;

	fpd_cordic #(
		.SAMPLE_BITS  (SAMPLE_BITS),
		.PHASE_BITS   (PHASE_BITS),
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cor_start),
		.sample_i(sample_i),
		.sample_q(sample_q),
		.done    (cor_done),
		.angle   (cor_angle)
	);

	// shared multiplier operand select, upper output product held while waiting
	always_comb begin
		case (state_q)
			S_MB, S_FRQ: mul_a = err_q;
			S_DL, S_OL:  mul_a = {{(MW-DLO_W){1'b0}}, diff_q[DLO_W-1:0]};
			S_DH, S_OH, S_OUT: mul_a = {{(MW-DIFF_W+DLO_W){diff_q[DIFF_W-1]}},
			                      diff_q[DIFF_W-1:DLO_W]};
			default:     mul_a = '0;
		endcase
		case (state_q)
			S_MB:       mul_b = loop_beta_q;
			S_FRQ:      mul_b = loop_alpha_q;
			S_DL, S_DH: mul_b = dc_alpha_q;
			S_OL, S_OH, S_OUT: mul_b = {{(COEF_W-OGAIN_W){1'b0}}, out_gain_q};
			default:    mul_b = '0;
		endcase
	end

	always_comb begin
		prod  = mul_a * $signed({1'b0, mul_b});
		s_sum = cor_angle + nco_q;
		s_ext = {{(MW-PHASE_BITS){s_sum[PHASE_BITS-1]}}, s_sum};
		err_n = zero_q ? '0 : -s_ext;

		pr_rnd   = prod_q + PW'(1 << (GAIN_FRAC - 1));
		pr_shift = pr_rnd >>> GAIN_FRAC;
		rnd_p    = pr_shift[NW-1:0];

		lf_ext   = {{(NW-FREQ_W){lf_q[FREQ_W-1]}}, lf_q};
		freq_sum = lf_ext + rnd_p;
		lim      = {{(NW-LIMIT_W){1'b0}}, freq_limit_q};
		neg_lim  = -lim;
		nco_ext  = {{(NW-PHASE_BITS){1'b0}}, nco_q};
		ph_sum   = nco_ext + lf_ext + rnd_p;

		diff_n = {lf_q[FREQ_W-1], lf_q, {GAIN_FRAC{1'b0}}} - {dc_q[DC_W-1], dc_q};

		acc_sum = acc_q + ({{(ACC_W-PW){prod_q[PW-1]}}, prod_q} <<< DLO_W);
		acc_dc  = (acc_sum + ACC_W'(1 << (GAIN_FRAC - 1))) >>> GAIN_FRAC;
		dc_n    = dc_q + acc_dc[DC_W-1:0];
		acc_out = (acc_sum + (ACC_W'(1) <<< (GAIN_FRAC + 15))) >>> (GAIN_FRAC + 16);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_alpha_q <= '0;
			loop_beta_q  <= '0;
			freq_limit_q <= '0;
			dc_alpha_q   <= '0;
			out_gain_q   <= OGAIN_W'(256);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LOOP_ALPHA: loop_alpha_q <= cfg_data[COEF_W-1:0];
				REG_LOOP_BETA:  loop_beta_q  <= cfg_data[COEF_W-1:0];
				REG_FREQ_LIMIT: freq_limit_q <= cfg_data[LIMIT_W-1:0];
				REG_DC_ALPHA:   dc_alpha_q   <= cfg_data[COEF_W-1:0];
				REG_OUT_GAIN:   out_gain_q   <= cfg_data[OGAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= prod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			nco_q       <= '0;
			lf_q        <= '0;
			dc_q        <= '0;
			zero_q      <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						zero_q  <= in_zero;
						state_q <= in_zero ? S_ERR : S_ROT;
					end
				end
				S_ROT: begin
					if (cor_done) begin
						state_q <= S_ERR;
					end
				end
				S_ERR: begin
					err_q   <= err_n;
					state_q <= S_MB;
				end
				S_MB: state_q <= S_FRQ;
				S_FRQ: begin
					if (freq_sum > lim) begin
						lf_q <= lim[FREQ_W-1:0];
					end else if (freq_sum < neg_lim) begin
						lf_q <= neg_lim[FREQ_W-1:0];
					end else begin
						lf_q <= freq_sum[FREQ_W-1:0];
					end
					state_q <= S_PH;
				end
				S_PH: begin
					nco_q   <= ph_sum[PHASE_BITS-1:0];
					diff_q  <= diff_n;
					state_q <= S_DL;
				end
				S_DL: state_q <= S_DH;
				S_DH: begin
					acc_q   <= {{(ACC_W-PW){prod_q[PW-1]}}, prod_q};
					state_q <= S_DC;
				end
				S_DC: begin
					dc_q    <= dc_n;
					state_q <= S_D2;
				end
				S_D2: begin
					diff_q  <= diff_n;
					state_q <= S_OL;
				end
				S_OL: state_q <= S_OH;
				S_OH: begin
					acc_q   <= {{(ACC_W-PW){prod_q[PW-1]}}, prod_q};
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						if (acc_out > ACC_W'(32767)) begin
							audio_q <= 16'sd32767;
						end else if (acc_out < -ACC_W'(32768)) begin
							audio_q <= -16'sd32768;
						end else begin
							audio_q <= acc_out[AUDIO_W-1:0];
						end
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign audio_out = audio_q;
	assign cfg_ready = 1'b1;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("sequencer took a request but stayed idle");

	a_cordic_done_in_rot: assert property (@(posedge clk) disable iff (!arst_n)
		cor_done |-> (state_q == S_ROT))
		else $error("cordic finished outside the rotation state");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_OUT))
		else $error("result appeared without finishing a sample");

	a_zero_skips_cordic: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ERR) && zero_q |-> !cor_done)
		else $error("cordic ran on a zero sample");

endmodule

### hw/rtl/fpd_cordic.sv
module fpd_cordic import fpd_pkg::*; #(
	parameter int SAMPLE_BITS   = 16,
	parameter int PHASE_BITS    = 24,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [SAMPLE_BITS-1:0] sample_i,
	input  logic signed [SAMPLE_BITS-1:0] sample_q,
	output logic                          done,
	output logic [PHASE_BITS-1:0]         angle
);

	localparam int CW = SAMPLE_BITS + GUARD_BITS + 2;
	localparam int KW = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
	localparam logic [KW-1:0] K_LAST = KW'(CORDIC_STAGES - 1);

	typedef enum logic {C_IDLE, C_RUN} cstate_t;

	cstate_t               state_q;
	logic                  done_q;
	logic [KW-1:0]         k_q;
	logic signed [CW-1:0]  x_q, y_q;
	logic [PHASE_BITS-1:0] z_q;

	logic signed [CW-1:0]  xs, ys, dx, dy;
	logic [31:0]           stp_full;
	logic [PHASE_BITS-1:0] stp;

	always_comb begin
		xs = {{2{sample_i[SAMPLE_BITS-1]}}, sample_i, {GUARD_BITS{1'b0}}};
		ys = {{2{sample_q[SAMPLE_BITS-1]}}, sample_q, {GUARD_BITS{1'b0}}};
		dx = y_q >>> k_q;
		dy = x_q >>> k_q;
		stp_full = atan_step(5'(k_q), PHASE_BITS);
		stp = stp_full[PHASE_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q  <= 1'b0;
			k_q     <= '0;
		end else begin
			case (state_q)
				C_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						// left half plane: turn by half a turn first
						if (xs < 0) begin
							x_q <= -xs;
							y_q <= -ys;
							z_q <= {1'b1, {(PHASE_BITS-1){1'b0}}};
						end else begin
							x_q <= xs;
							y_q <= ys;
							z_q <= '0;
						end
						k_q     <= '0;
						state_q <= C_RUN;
					end
				end
				C_RUN: begin
					if (y_q >= 0) begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						z_q <= z_q + stp;
					end else begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						z_q <= z_q - stp;
					end
					if (k_q == K_LAST) begin
						done_q  <= 1'b1;
						state_q <= C_IDLE;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign done  = done_q;
	assign angle = z_q;

endmodule

### dv/tb.sv
module tb import fpd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PBITS = 24;
	localparam int STAGES = 16;
	localparam logic [CFG_IDX_W-1:0] REG_NONE_A = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_NONE_B = 3'd7;
	localparam int IDLE_WAIT = 40;
	localparam longint CYCLE_LIMIT = 2000000;

	class demod_scoreboard;
		bit [COEF_W-1:0] alpha, beta, dc_coef;
		bit [LIMIT_W-1:0] limit;
		bit [OGAIN_W-1:0] gain;
		bit [PBITS-1:0] phase;
		longint freq, dc_level;
		logic signed [AUDIO_W-1:0] audio_q[$];
		int errors;

		function new();
			alpha = 0; beta = 0; limit = 0; dc_coef = 0; gain = 256;
			phase = 0; freq = 0; dc_level = 0; errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
				REG_LOOP_ALPHA: alpha = d[COEF_W-1:0];
				REG_LOOP_BETA: beta = d[COEF_W-1:0];
				REG_FREQ_LIMIT: limit = d[LIMIT_W-1:0];
				REG_DC_ALPHA: dc_coef = d[COEF_W-1:0];
				REG_OUT_GAIN: gain = d[OGAIN_W-1:0];
				default: ;
			endcase
		endfunction

		function longint round_shift(longint v, int n);
			return (v + (longint'(1) << (n - 1))) >>> n;
		endfunction

		function longint vector_angle(longint x, longint y);
			longint z, dx, dy, step;
			z = 0;
			x = x <<< GUARD_BITS;
			y = y <<< GUARD_BITS;
			if (x < 0) begin
				x = -x; y = -y;
				z = longint'(1) << (PBITS - 1);
			end
			for (int k = 0; k < STAGES; k++) begin
				dx = y >>> k;
				dy = x >>> k;
				step = (((longint'(ATAN_TURN32[k]) << 1) >> (32 - PBITS)) + 1) >> 1;
				if (y >= 0) begin
					x += dx; y -= dy; z += step;
				end else begin
					x -= dx; y += dy; z -= step;
				end
			end
			return z;
		endfunction

		function void note_sample(logic signed [15:0] si, logic signed [15:0] sq);
			longint err, s, diff, res, lim;
			err = 0;
			lim = longint'(limit);
			if (si != 0 || sq != 0) begin
				s = (vector_angle(si, sq) + longint'(phase)) & ((longint'(1) << PBITS) - 1);
				if (s[PBITS-1])
					s -= longint'(1) << PBITS;
				err = -s;
			end
			freq += round_shift(longint'(beta) * err, GAIN_FRAC);
			if (freq > lim) freq = lim;
			if (freq < -lim) freq = -lim;
			s = longint'(phase) + freq + round_shift(longint'(alpha) * err, GAIN_FRAC);
			phase = s[PBITS-1:0];
			diff = (freq <<< GAIN_FRAC) - dc_level;
			dc_level += round_shift(longint'(dc_coef) * diff, GAIN_FRAC);
			diff = (freq <<< GAIN_FRAC) - dc_level;
			res = round_shift(diff * longint'(gain), GAIN_FRAC + 16);
			if (res > 32767) res = 32767;
			if (res < -32768) res = -32768;
			audio_q.push_back(res[15:0]);
		endfunction

		function void check_audio(logic signed [AUDIO_W-1:0] got);
			logic signed [AUDIO_W-1:0] want;
			if (audio_q.size() == 0) begin
				$error("audio_out: unexpected result %0d", got);
				errors++;
				return;
			end
			want = audio_q.pop_front();
			if (got !== want) begin
				$error("audio_out: expected %0d, got %0d", want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic signed [15:0] sample_i = 0, sample_q = 0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [AUDIO_W-1:0] audio_out;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = 0;
	logic [CFG_DATA_W-1:0] cfg_data = 0;

	demod_scoreboard sb = new();
	longint cycles = 0;
	int stall_mode = 0;
	int hold_off = 0;
	int max_gap = 0;
	int burst_left = 0;
	real carrier = 0.0;

	fm_pll_demodulator dut (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL fm_pll_demodulator");
			$finish;
		end
	end

	// receiver: long hold-off first, then its own stall pattern
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 0;
		end else begin
			case (stall_mode)
				0: out_ready <= 1;
				1: out_ready <= ($urandom_range(0, 99) < 65);
				default: out_ready <= (cycles % 37) > 20;
			endcase
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_audio(audio_out);

	task automatic send_sample(logic signed [15:0] si, logic signed [15:0] sq);
		int gap;
		in_valid <= 1;
		sample_i <= si;
		sample_q <= sq;
		do @(posedge clk); while (!in_ready);
		sb.note_sample(si, sq);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 20);
			gap = (max_gap == 0) ? 0 : $urandom_range(1, max_gap);
			if (gap > 0) begin
				in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic settle();
		in_valid <= 0;
		while (sb.audio_q.size() != 0) @(posedge clk);
		repeat (IDLE_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, d);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic load_regs(int a, int b, int lim, int dca, int g);
		write_reg(REG_LOOP_ALPHA, CFG_DATA_W'(a));
		write_reg(REG_LOOP_BETA, CFG_DATA_W'(b));
		write_reg(REG_FREQ_LIMIT, CFG_DATA_W'(lim));
		write_reg(REG_DC_ALPHA, CFG_DATA_W'(dca));
		write_reg(REG_OUT_GAIN, CFG_DATA_W'(g));
	endtask

	// mostly a modulated phasor the loop can follow, the rest noise and zeros
	task automatic run_phase(int n, real dev);
		real amp, rate;
		int pick;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				amp = $urandom_range(100, 32000);
				rate = dev * $sin(6.2831853 * k / 60.0);
				carrier = carrier + rate;
				carrier = carrier - $floor(carrier);
				send_sample(16'($rtoi(amp * $cos(6.2831853 * carrier))),
					16'($rtoi(amp * $sin(6.2831853 * carrier))));
			end else if (pick < 80) begin
				send_sample(0, 0);
			end else begin
				send_sample(16'($urandom), 16'($urandom));
			end
		end
		settle();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// reset settings: loop frozen, plain extremes and tiny values of the inputs
		send_sample(0, 0);
		send_sample(32767, 0);
		send_sample(-32768, 0);
		send_sample(0, 32767);
		send_sample(0, -32768);
		send_sample(-32768, -32768);
		send_sample(32767, 32767);
		send_sample(-32768, 32767);
		send_sample(1, 0);
		send_sample(-1, -1);
		settle();

		load_regs(262143, 262143, 8388607, 262143, 65535);
		write_reg(REG_NONE_A, 8388607);
		write_reg(REG_NONE_B, 0);
		send_sample(32767, -32768);
		send_sample(-32768, 1);
		send_sample(0, 0);
		send_sample(-32768, -1);
		send_sample(0, 0);
		send_sample(12345, -23456);
		send_sample(-1, 32767);
		settle();

		// limit lowered while loop frequency sits high
		write_reg(REG_FREQ_LIMIT, 1000);
		send_sample(-32768, 100);
		send_sample(0, 0);
		send_sample(100, 32767);
		settle();

		max_gap = 8; stall_mode = 1;
		load_regs(20000, 600, 1 << 20, 200, 256);
		run_phase(200, 0.01);

		max_gap = 0; stall_mode = 0;
		load_regs(262143, 262143, 8388607, 262143, 65535);
		run_phase(180, 0.2);

		max_gap = 3; stall_mode = 2;
		load_regs(0, 0, 0, 0, 0);
		run_phase(100, 0.05);

		max_gap = 0; stall_mode = 1;
		load_regs(40000, 2000, 300000, 0, 4096);
		hold_off <= 400;
		run_phase(200, 0.02);

		max_gap = 12; stall_mode = 1;
		load_regs(5000, 100, 8388607, 2000, 1024);
		run_phase(230, 0.005);

		max_gap = 2; stall_mode = 2;
		load_regs($urandom_range(0, 262143), $urandom_range(0, 262143),
			$urandom_range(0, 8388607), $urandom_range(0, 262143), $urandom_range(0, 65535));
		run_phase(200, 0.1);

		repeat (IDLE_WAIT) @(posedge clk);
		if (sb.errors == 0 && sb.audio_q.size() == 0)
			$display("PASS fm_pll_demodulator");
		else
			$display("FAIL fm_pll_demodulator");
		$finish;
	end
endmodule
